>>> design/rnpp_pkg.sv
// Shared types, widths and constants for the ray nearest-point pick block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package rnpp_pkg;

  // Field formats: s3.12 coordinates, u3.12 radius, u6.12 ray parameter
  localparam int COORD_W   = 16;
  localparam int DIST_W    = 15;
  localparam int FRAC_BITS = 12;
  localparam int T_W       = 18;
  localparam int INDEX_W   = 12;
  localparam int NUM_AXES  = 3;
  localparam int CFG_IDX_W = 3;

  // Internal arithmetic widths
  localparam int DIFF_W     = COORD_W + 1;             // p - o
  localparam int MUL_W      = 24;                      // lane multiplier operand
  localparam int PROD_W     = 2 * MUL_W;               // lane multiplier product
  localparam int DOT_W      = DIFF_W + COORD_W + 2;    // sum of three diff*dir
  localparam int DOT_HI_W   = DOT_W - FRAC_BITS;       // dot >> FRAC_BITS
  localparam int SCALE_W    = COORD_W + T_W + 1;       // dir * t
  localparam int SH_W       = SCALE_W - FRAC_BITS;     // (dir * t) >> FRAC_BITS
  localparam int SQ_TERM_W  = 46;                      // one squared error term
  localparam int SQ_SUM_W   = SQ_TERM_W + 2;           // sum of three terms
  localparam int SQ_W       = 40;                      // stored squared distance
  localparam int MDSQ_W     = 2 * DIST_W;              // radius squared
  localparam int TGT_W      = SH_W + 1;                // o + shifted scale

  localparam logic [T_W-1:0]  T_MAX  = '1;
  localparam logic [SQ_W-1:0] SQ_MAX = '1;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = 16'sh7FFF;
  localparam coord_t COORD_MIN = 16'sh8000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_MAX_DIST = 3'd6
  } reg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOT,
    ST_TPAR,
    ST_SCALE,
    ST_ERR,
    ST_CMP,
    ST_FIN_SCALE,
    ST_FIN_LOAD
  } state_t;

  // Operand selection for the three lane multipliers
  typedef enum logic [2:0] {
    MUL_HOLD,
    MUL_DOT,
    MUL_SCALE,
    MUL_ERR,
    MUL_TARGET
  } mul_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_item;
    mul_sel_t mul_sel;
    logic     calc_t;
    logic     compare;
    logic     load_result;
    logic     clear_pass;
  } rnpp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
  } rnpp_stat_t;

  // Clamp a widened coordinate sum to s16
  function automatic coord_t sat_coord(input logic signed [TGT_W-1:0] v);
    coord_t r;
    if (v > TGT_W'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (v < TGT_W'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/rnpp_if.sv
// Valid/ready channel interfaces: particle items in, pick results out.
// Depends on rnpp_pkg.
interface rnpp_particle_if import rnpp_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  logic   pinned;
  logic   last_particle;

  modport source (output valid, pos_x, pos_y, pos_z, pinned, last_particle, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, pinned, last_particle, output ready);
endinterface

interface rnpp_pick_if import rnpp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [INDEX_W-1:0] best_index;
  logic [T_W-1:0]     best_t;
  coord_t             target_x;
  coord_t             target_y;
  coord_t             target_z;

  modport source (output valid, found, best_index, best_t, target_x, target_y, target_z,
                  input ready);
  modport sink   (input valid, found, best_index, best_t, target_x, target_y, target_z,
                  output ready);
endinterface

>>> design/rnpp_datapath.sv
// Datapath: configuration registers, three shared lane multipliers, running
// minimum over the pass and the result register. Depends on rnpp_pkg.
module rnpp_datapath import rnpp_pkg::*; #(
  parameter int MAX_PARTICLES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  input  coord_t               pos_x,
  input  coord_t               pos_y,
  input  coord_t               pos_z,
  input  logic                 pinned,
  input  logic                 last_particle,
  input  rnpp_cmd_t            cmd,
  output rnpp_stat_t           stat,
  output logic                 found,
  output logic [INDEX_W-1:0]   best_index,
  output logic [T_W-1:0]       best_t,
  output coord_t               target_x,
  output coord_t               target_y,
  output coord_t               target_z
);

  localparam int CNT_W = $clog2(MAX_PARTICLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_PARTICLES - 1);

  // Configuration
  coord_t              origin [NUM_AXES];
  coord_t              dir    [NUM_AXES];
  logic [DIST_W-1:0]   max_distance;
  logic [MDSQ_W-1:0]   md_sq;
  logic                dir_zero;

  // Current item
  coord_t                    pos  [NUM_AXES];
  logic signed [DIFF_W-1:0]  diff [NUM_AXES];
  logic                      skip;
  logic                      last_item;

  // Lane multipliers
  logic signed [MUL_W-1:0]   op_a [NUM_AXES];
  logic signed [MUL_W-1:0]   op_b [NUM_AXES];
  logic signed [PROD_W-1:0]  prod [NUM_AXES];
  logic signed [SH_W-1:0]    sh   [NUM_AXES];
  logic signed [MUL_W-1:0]   err  [NUM_AXES];

  // Ray parameter
  logic signed [DOT_W-1:0]   dot_sum;
  logic [DOT_HI_W-1:0]       dot_hi;
  logic                      dot_neg;
  logic [T_W-1:0]            t_par;

  // Running minimum
  logic [SQ_SUM_W-1:0]       sq_sum;
  logic [SQ_W-1:0]           sq_sat;
  logic [SQ_W-1:0]           bound;
  logic                      hit;
  logic [CNT_W-1:0]          item_count;
  logic [SQ_W-1:0]           best_sq_dist;
  logic [CNT_W-1:0]          best_slot;
  logic [T_W-1:0]            best_param;
  logic                      any_found;

  // Target
  logic signed [TGT_W-1:0]   tgt_sum [NUM_AXES];
  coord_t                    tgt_sat [NUM_AXES];

  // Configuration writes; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        origin[a] <= '0;
        dir[a]    <= '0;
      end
      max_distance <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin[0]    <= cfg_data;
        REG_ORIGIN_Y: origin[1]    <= cfg_data;
        REG_ORIGIN_Z: origin[2]    <= cfg_data;
        REG_DIR_X:    dir[0]       <= cfg_data;
        REG_DIR_Y:    dir[1]       <= cfg_data;
        REG_DIR_Z:    dir[2]       <= cfg_data;
        REG_MAX_DIST: max_distance <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Radius squared, refreshed every cycle from the live register
  always_ff @(posedge clk) begin
    if (rst) begin
      md_sq <= '0;
    end else begin
      md_sq <= max_distance * max_distance;
    end
  end

  assign dir_zero = (dir[0] == '0) && (dir[1] == '0) && (dir[2] == '0);

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  // Capture the particle as p - o
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        diff[a] <= DIFF_W'(pos[a]) - DIFF_W'(origin[a]);
      end
      skip      <= pinned | dir_zero;
      last_item <= last_particle;
    end
  end

  assign stat.last = last_item;

  // Operand muxes; the error step subtracts the floored scale from the diff
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sh[a]  = $signed(prod[a][SCALE_W-1:FRAC_BITS]);
      err[a] = MUL_W'(diff[a]) - MUL_W'(sh[a]);
      case (cmd.mul_sel)
        MUL_DOT: begin
          op_a[a] = MUL_W'(diff[a]);
          op_b[a] = MUL_W'(dir[a]);
        end
        MUL_SCALE: begin
          op_a[a] = MUL_W'(dir[a]);
          op_b[a] = $signed(MUL_W'(t_par));
        end
        MUL_ERR: begin
          op_a[a] = err[a];
          op_b[a] = err[a];
        end
        MUL_TARGET: begin
          op_a[a] = MUL_W'(dir[a]);
          op_b[a] = $signed(MUL_W'(best_param));
        end
        default: begin
          op_a[a] = '0;
          op_b[a] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MUL_HOLD) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod[a] <= op_a[a] * op_b[a];
      end
    end
  end

  // t = floor(dot >> FRAC_BITS), clamped; sign kept for the skip test
  assign dot_sum = $signed(prod[0][DOT_W-1:0]) + $signed(prod[1][DOT_W-1:0])
                 + $signed(prod[2][DOT_W-1:0]);
  assign dot_hi  = dot_sum[DOT_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (cmd.calc_t) begin
      dot_neg <= dot_sum[DOT_W-1];
      t_par   <= (dot_hi > DOT_HI_W'(T_MAX)) ? T_MAX : dot_hi[T_W-1:0];
    end
  end

  // Squared distance against the best so far (radius squared before a hit)
  assign sq_sum = SQ_SUM_W'(prod[0][SQ_TERM_W-1:0]) + SQ_SUM_W'(prod[1][SQ_TERM_W-1:0])
                + SQ_SUM_W'(prod[2][SQ_TERM_W-1:0]);
  assign sq_sat = (sq_sum > SQ_SUM_W'(SQ_MAX)) ? SQ_MAX : sq_sum[SQ_W-1:0];
  assign bound  = any_found ? best_sq_dist : SQ_W'(md_sq);
  assign hit    = !skip && !dot_neg && (sq_sat < bound);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_pass) begin
      item_count   <= '0;
      best_sq_dist <= '0;
      best_slot    <= '0;
      best_param   <= '0;
      any_found    <= 1'b0;
    end else if (cmd.compare) begin
      if (hit) begin
        best_sq_dist <= sq_sat;
        best_slot    <= item_count;
        best_param   <= t_par;
        any_found    <= 1'b1;
      end
      item_count <= (item_count == CNT_LAST) ? '0 : item_count + 1'b1;
    end
  end

  // Drag target o + (d * t >> FRAC_BITS), clamped to s16
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      tgt_sum[a] = TGT_W'(origin[a]) + TGT_W'(sh[a]);
      tgt_sat[a] = sat_coord(tgt_sum[a]);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      found      <= any_found;
      best_index <= any_found ? INDEX_W'(best_slot) : '0;
      best_t     <= any_found ? best_param : '0;
      target_x   <= any_found ? tgt_sat[0] : '0;
      target_y   <= any_found ? tgt_sat[1] : '0;
      target_z   <= any_found ? tgt_sat[2] : '0;
    end
  end

endmodule

>>> design/rnpp_ctrl.sv
// Controller: sequences the lane multipliers through dot, scale, error and
// compare steps per particle, and owns the input ready and result valid.
// Depends on rnpp_pkg.
module rnpp_ctrl import rnpp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  rnpp_stat_t stat,
  output rnpp_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next      = state;
    cmd.load_item   = 1'b0;
    cmd.mul_sel     = MUL_HOLD;
    cmd.calc_t      = 1'b0;
    cmd.compare     = 1'b0;
    cmd.load_result = 1'b0;
    cmd.clear_pass  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DOT;
        end
      end
      ST_DOT: begin
        cmd.mul_sel = MUL_DOT;
        state_next  = ST_TPAR;
      end
      ST_TPAR: begin
        cmd.calc_t = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.mul_sel = MUL_SCALE;
        state_next  = ST_ERR;
      end
      ST_ERR: begin
        cmd.mul_sel = MUL_ERR;
        state_next  = ST_CMP;
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_next  = stat.last ? ST_FIN_SCALE : ST_IDLE;
      end
      ST_FIN_SCALE: begin
        cmd.mul_sel = MUL_TARGET;
        state_next  = ST_FIN_LOAD;
      end
      ST_FIN_LOAD: begin
        // wait for the result register to free up
        if (!out_valid || out_ready) begin
          cmd.load_result = 1'b1;
          cmd.clear_pass  = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Result valid: set on load, cleared when taken
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (cmd.load_result) begin
      out_valid_next = 1'b1;
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("rnpp_ctrl: took a second particle while one is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> (!out_valid || out_ready))
    else $error("rnpp_ctrl: result register overwritten before taken");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |=> out_valid)
    else $error("rnpp_ctrl: loaded result not presented");

  a_cmp_return: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP && !stat.last) |=> in_ready)
    else $error("rnpp_ctrl: no return to idle after a non-final particle");

endmodule

>>> design/ray_nearest_point_pick_unit.sv
// Ray nearest-point pick, top level. Each particle goes from acceptance to the
// next acceptance through accept, dot, t, scale, error square and compare,
// with the three lane multipliers stepped through dot, scale and squaring in turn.
// The last particle of a pass adds target scale and a result load, which waits
// for a free result register; the result register then holds the result while
// new particles are taken. Synchronous reset clears config, pass state and valid.
module ray_nearest_point_pick_unit import rnpp_pkg::*; #(
  parameter int MAX_PARTICLES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  rnpp_particle_if.sink        particle,
  rnpp_pick_if.source          pick,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  rnpp_cmd_t  cmd;
  rnpp_stat_t stat;

  // Sequencer
  rnpp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (particle.valid),
    .in_ready  (particle.ready),
    .out_valid (pick.valid),
    .out_ready (pick.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and pass state
  rnpp_datapath #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pos_x         (particle.pos_x),
    .pos_y         (particle.pos_y),
    .pos_z         (particle.pos_z),
    .pinned        (particle.pinned),
    .last_particle (particle.last_particle),
    .cmd           (cmd),
    .stat          (stat),
    .found         (pick.found),
    .best_index    (pick.best_index),
    .best_t        (pick.best_t),
    .target_x      (pick.target_x),
    .target_y      (pick.target_y),
    .target_z      (pick.target_z)
  );

endmodule

>>> dv/ray_nearest_point_pick_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the ray nearest-point pick unit: follows config writes and particle
// transactions, predicts each pick result and checks it on the result channel.
// Depends on rnpp_pkg and the rnpp_particle_if / rnpp_pick_if interfaces.
module ray_nearest_point_pick_checker import rnpp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  rnpp_particle_if             particle,
  rnpp_pick_if                 pick,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  output int                   picks_pending,
  output int                   mismatches
);

  localparam longint T_LIMIT  = (longint'(1) << T_W) - 1;
  localparam longint SQ_LIMIT = (longint'(1) << SQ_W) - 1;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] best_index;
    logic [T_W-1:0]     best_t;
    coord_t             target_x;
    coord_t             target_y;
    coord_t             target_z;
  } pick_result_t;

  // Ray configuration as the block should hold it
  coord_t             ray_origin [NUM_AXES];
  coord_t             ray_dir    [NUM_AXES];
  logic [DIST_W-1:0]  pick_radius;

  // Running state of the current pass
  logic [INDEX_W-1:0] slot_count;
  longint             best_dist_sq;
  logic [INDEX_W-1:0] best_slot;
  longint             best_param;
  bit                 hit_seen;

  pick_result_t       expected_picks [$];
  int                 error_count = 0;

  function automatic coord_t clamp_coord(input longint v);
    if (v > 32767) return COORD_MAX;
    if (v < -32768) return COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic void clear_pass();
    slot_count   = '0;
    best_dist_sq = 0;
    best_slot    = '0;
    best_param   = 0;
    hit_seen     = 1'b0;
  endfunction

  // Advance the pass by one particle; the closing particle queues a pick result
  task automatic track_particle(input coord_t px, input coord_t py, input coord_t pz,
                                input logic pinned, input logic last);
    longint       pos  [NUM_AXES];
    longint       diff [NUM_AXES];
    longint       dir  [NUM_AXES];
    longint       dot;
    longint       t_par;
    longint       dist_sq;
    longint       err;
    longint       bound;
    pick_result_t res;
    pos[0] = longint'(px);
    pos[1] = longint'(py);
    pos[2] = longint'(pz);
    for (int a = 0; a < NUM_AXES; a++) begin
      dir[a]  = longint'(ray_dir[a]);
      diff[a] = pos[a] - longint'(ray_origin[a]);
    end
    if (!pinned && (dir[0] != 0 || dir[1] != 0 || dir[2] != 0)) begin
      dot = diff[0] * dir[0] + diff[1] * dir[1] + diff[2] * dir[2];
      // behind the origin: skipped
      if (dot >= 0) begin
        t_par = dot >>> FRAC_BITS;
        if (t_par > T_LIMIT) t_par = T_LIMIT;
        dist_sq = 0;
        for (int a = 0; a < NUM_AXES; a++) begin
          err = diff[a] - ((dir[a] * t_par) >>> FRAC_BITS);
          dist_sq += err * err;
        end
        if (dist_sq > SQ_LIMIT) dist_sq = SQ_LIMIT;
        // live radius until the first hit, then the best so far; strict, so ties keep the first
        bound = hit_seen ? best_dist_sq : longint'(pick_radius) * longint'(pick_radius);
        if (dist_sq < bound) begin
          best_dist_sq = dist_sq;
          best_slot    = slot_count;
          best_param   = t_par;
          hit_seen     = 1'b1;
        end
      end
    end
    slot_count = slot_count + 1'b1;
    if (last) begin
      res = '0;
      if (hit_seen) begin
        res.found      = 1'b1;
        res.best_index = best_slot;
        res.best_t     = best_param[T_W-1:0];
        res.target_x   = clamp_coord(longint'(ray_origin[0]) +
                                     ((dir[0] * best_param) >>> FRAC_BITS));
        res.target_y   = clamp_coord(longint'(ray_origin[1]) +
                                     ((dir[1] * best_param) >>> FRAC_BITS));
        res.target_z   = clamp_coord(longint'(ray_origin[2]) +
                                     ((dir[2] * best_param) >>> FRAC_BITS));
      end
      expected_picks.push_back(res);
      clear_pass();
    end
  endtask

  task automatic check_field(input string field, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("pick field %s: expected %0d, actual %0d", field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    pick_result_t want;
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        ray_origin[a] = '0;
        ray_dir[a]    = '0;
      end
      pick_radius = '0;
      clear_pass();
      expected_picks.delete();
    end else begin
      // config register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X: ray_origin[0] = coord_t'(cfg_data);
          REG_ORIGIN_Y: ray_origin[1] = coord_t'(cfg_data);
          REG_ORIGIN_Z: ray_origin[2] = coord_t'(cfg_data);
          REG_DIR_X:    ray_dir[0]    = coord_t'(cfg_data);
          REG_DIR_Y:    ray_dir[1]    = coord_t'(cfg_data);
          REG_DIR_Z:    ray_dir[2]    = coord_t'(cfg_data);
          REG_MAX_DIST: pick_radius   = cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
      // result transaction against the oldest prediction
      if (pick.valid && pick.ready) begin
        if (expected_picks.size() == 0) begin
          $error("pick result with no prediction pending");
          error_count++;
        end else begin
          want = expected_picks.pop_front();
          check_field("found",      want.found,      pick.found);
          check_field("best_index", want.best_index, pick.best_index);
          check_field("best_t",     want.best_t,     pick.best_t);
          check_field("target_x",   want.target_x,   pick.target_x);
          check_field("target_y",   want.target_y,   pick.target_y);
          check_field("target_z",   want.target_z,   pick.target_z);
        end
      end
      // particle transaction
      if (particle.valid && particle.ready) begin
        track_particle(particle.pos_x, particle.pos_y, particle.pos_z,
                       particle.pinned, particle.last_particle);
      end
    end
    picks_pending <= expected_picks.size();
    mismatches    <= error_count;
  end

endmodule

>>> dv/tb_ray_nearest_point_pick_unit.sv
`timescale 1ns / 1ps
// Testbench top for the ray nearest-point pick unit: clock, reset, config writes,
// particle stimulus and result back-pressure; checking sits in the scoreboard module.
// Depends on rnpp_pkg, the channel interfaces, the unit and the scoreboard.
module tb_ray_nearest_point_pick_unit import rnpp_pkg::*; ();

  localparam int     RANDOM_ITEMS   = 1050;
  localparam int     HOLDOFF_CYCLES = 300;
  localparam int     SETTLE_CYCLES  = 12;
  localparam longint TIMEOUT_NS     = 4_000_000;

  typedef enum logic [1:0] {RX_RANDOM, RX_STEADY, RX_HOLD} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;
  int                   picks_pending;
  int                   mismatches;

  // stimulus-side copy of the ray, used only to aim particles
  coord_t               cur_origin [NUM_AXES];
  coord_t               cur_dir    [NUM_AXES];
  logic [DIST_W-1:0]    cur_radius;

  rx_mode_t             rx_mode       = RX_RANDOM;
  bit                   holdoff_done  = 1'b0;
  bit                   tx_gaps       = 1'b1;
  int                   items_sent    = 0;

  rnpp_particle_if particle ();
  rnpp_pick_if     pick ();

  ray_nearest_point_pick_unit dut (
    .clk       (clk),
    .rst       (rst),
    .particle  (particle),
    .pick      (pick),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ray_nearest_point_pick_checker scoreboard (
    .clk           (clk),
    .rst           (rst),
    .particle      (particle),
    .pick          (pick),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .picks_pending (picks_pending),
    .mismatches    (mismatches)
  );

  always #10 clk = ~clk;

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  // Result side back-pressure: random, steady, or one long counted hold-off
  initial begin
    pick.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_mode == RX_HOLD && !holdoff_done) begin
        pick.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_done = 1'b1;
      end else begin
        pick.ready <= (rx_mode == RX_STEADY) || ($urandom_range(99) >= 11);
        @(posedge clk);
      end
    end
  end

  function automatic coord_t clamp_coord(input longint v);
    if (v > 32767) return COORD_MAX;
    if (v < -32768) return COORD_MIN;
    return coord_t'(v);
  endfunction

  // Point on the current ray at parameter s (Q12), jittered by up to spread per axis
  function automatic coord_t ray_point(input int axis, input longint s, input int spread);
    longint v;
    v = longint'(cur_origin[axis]) + ((longint'(cur_dir[axis]) * s) >>> FRAC_BITS) +
        longint'($urandom_range(0, 2 * spread)) - longint'(spread);
    return clamp_coord(v);
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [COORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Program all seven registers; called only while the unit is idle
  task automatic apply_ray(input coord_t ox, input coord_t oy, input coord_t oz,
                           input coord_t dx, input coord_t dy, input coord_t dz,
                           input logic [COORD_W-1:0] radius_word);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    write_reg(REG_MAX_DIST, radius_word);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_origin[0] = ox;
    cur_origin[1] = oy;
    cur_origin[2] = oz;
    cur_dir[0]    = dx;
    cur_dir[1]    = dy;
    cur_dir[2]    = dz;
    cur_radius    = radius_word[DIST_W-1:0];
  endtask

  // One particle transaction; valid stays up afterwards for a back-to-back item
  task automatic send_particle(input coord_t x, input coord_t y, input coord_t z,
                               input logic pinned, input logic last);
    if (tx_gaps) begin
      while ($urandom_range(99) < 11) begin
        particle.valid <= 1'b0;
        @(posedge clk);
      end
    end
    particle.valid         <= 1'b1;
    particle.pos_x         <= x;
    particle.pos_y         <= y;
    particle.pos_z         <= z;
    particle.pinned        <= pinned;
    particle.last_particle <= last;
    @(posedge clk);
    while (!particle.ready) @(posedge clk);
    items_sent++;
  endtask

  // Mostly particles near the ray, some anywhere, a few pinned
  task automatic send_random_particle(input logic last);
    longint s;
    int     spread;
    bit     anywhere;
    coord_t p [NUM_AXES];
    s        = longint'($urandom_range(0, 20480)) - 4096;
    spread   = $urandom_range(0, int'(cur_radius));
    anywhere = ($urandom_range(99) < 25);
    for (int a = 0; a < NUM_AXES; a++) begin
      p[a] = anywhere ? coord_t'($urandom) : ray_point(a, s, spread);
    end
    send_particle(p[0], p[1], p[2], $urandom_range(99) < 10, last);
  endtask

  task automatic random_ray();
    coord_t             o [NUM_AXES];
    coord_t             d [NUM_AXES];
    real                v [NUM_AXES];
    real                len;
    int                 kind;
    int                 rsel;
    logic [DIST_W-1:0]  radius;
    kind = $urandom_range(9);
    for (int a = 0; a < NUM_AXES; a++) begin
      o[a] = ($urandom_range(9) < 7) ? coord_t'(int'($urandom_range(0, 24000)) - 12000)
                                     : coord_t'($urandom);
      v[a] = real'($urandom_range(0, 8192)) - 4096.0;
      d[a] = '0;
    end
    len = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
    case (kind)
      0: ;  // zero direction: nothing can be picked
      1: begin
        for (int a = 0; a < NUM_AXES; a++) d[a] = coord_t'($urandom);
      end
      2, 3, 4: begin
        d[$urandom_range(2)] = $urandom_range(1) ? coord_t'(4096) : coord_t'(-4096);
      end
      default: begin
        // roughly unit length, so t is the true projection
        if (len > 1.0) begin
          for (int a = 0; a < NUM_AXES; a++) d[a] = coord_t'($rtoi(v[a] / len * 4096.0));
        end else begin
          d[0] = coord_t'(4096);
        end
      end
    endcase
    rsel = $urandom_range(19);
    if (rsel == 0) radius = '0;
    else if (rsel == 1) radius = '1;
    else radius = DIST_W'($urandom_range(1500, 20000));
    // top data bit is outside the radius register
    apply_ray(o[0], o[1], o[2], d[0], d[1], d[2], {1'($urandom_range(1)), radius});
  endtask

  // Drop valid, wait out every predicted pick, then let the unit settle
  task automatic drain_picks();
    particle.valid <= 1'b0;
    @(posedge clk);
    while (picks_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int     phase;
    int     random_base;
    int     pass_len;
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    particle.valid         = 1'b0;
    particle.pos_x         = '0;
    particle.pos_y         = '0;
    particle.pos_z         = '0;
    particle.pinned        = 1'b0;
    particle.last_particle = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      cur_origin[a] = '0;
      cur_dir[a]    = '0;
    end
    cur_radius = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero direction straight out of reset
    send_particle(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0);
    send_particle(COORD_MAX, COORD_MIN, 16'sd0, 1'b0, 1'b1);
    drain_picks();

    // Unit x axis, widest radius: hit, worse, tie, pinned, behind origin, pinned far off
    apply_ray(16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'h7FFF);
    send_particle(16'sd100, 16'sd0, 16'sd0, 1'b0, 1'b0);
    send_particle(16'sd200, 16'sd50, 16'sd0, 1'b0, 1'b0);
    send_particle(16'sd100, 16'sd0, 16'sd0, 1'b0, 1'b0);
    send_particle(16'sd300, 16'sd0, 16'sd0, 1'b1, 1'b0);
    send_particle(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
    send_particle(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
    drain_picks();

    // Zero radius: even an exact hit is not strictly nearer
    apply_ray(16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'h0000);
    send_particle(16'sd100, 16'sd0, 16'sd0, 1'b0, 1'b0);
    send_particle(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
    drain_picks();

    // Extreme origin and direction: t saturates, then a hit at the origin
    apply_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 16'h7FFF);
    send_particle(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
    send_particle(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b1);
    drain_picks();

    // Slightly long direction: target clamps high, then low
    apply_ray(16'sd0, 16'sd0, 16'sd0, 16'sd4100, 16'sd0, 16'sd0, 16'h7FFF);
    send_particle(COORD_MAX, 16'sd0, 16'sd0, 1'b0, 1'b1);
    drain_picks();
    apply_ray(16'sd0, 16'sd0, 16'sd0, -16'sd4100, 16'sd0, 16'sd0, 16'h7FFF);
    send_particle(COORD_MIN, 16'sd0, 16'sd0, 1'b0, 1'b1);
    drain_picks();

    // Most negative direction component
    apply_ray(16'sd1000, -16'sd1000, 16'sd0, COORD_MIN, 16'sd0, 16'sd0, 16'h7FFF);
    send_particle(-16'sd3000, -16'sd1000, 16'sd20, 1'b0, 1'b1);
    drain_picks();

    // Random phases, each with its own ray
    phase       = 0;
    random_base = items_sent;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      random_ray();
      if (phase == 3) begin
        // a long stretch with no idling on either side
        tx_gaps = 1'b0;
        rx_mode = RX_STEADY;
      end
      if (phase == 5) begin
        // receiver holds off while single-particle passes pile up
        tx_gaps = 1'b0;
        rx_mode = RX_HOLD;
        repeat (24) send_random_particle(1'b1);
      end else begin
        repeat (8) begin
          pass_len = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 16);
          for (int i = 0; i < pass_len; i++) send_random_particle(i == pass_len - 1);
        end
      end
      drain_picks();
      tx_gaps = 1'b1;
      rx_mode = RX_RANDOM;
      phase++;
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
